@@ hw/rtl/tsm_pkg.sv @@
// Shared types and defaults for the two-way sorted merge block.
package tsm_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int DATA_BITS_DEF = 32;
  localparam int VALUE_BITS    = 32;
  localparam int OPCODE_BITS   = 2;

  // request opcodes; code 3 has no meaning and is ignored
  typedef enum logic [OPCODE_BITS-1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_MERGE    = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

endpackage

@@ hw/rtl/tsm_list_mem.sv @@
// One list store: single write port, one registered read port.
module tsm_list_mem #(
  parameter int DEPTH     = tsm_pkg::DEPTH_DEF,
  parameter int DATA_BITS = tsm_pkg::DATA_BITS_DEF,
  parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data is registered and lands in the cycle after the address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/two_way_sorted_merge.sv @@
// Top level of the two-way sorted merge: list stores, merge sequencer, output register.
// Append requests are accepted back to back; they produce no result.
// Merge of N stored values: the first result passes the merge state and the output register,
//   then one per cycle while out_stall is low; the input is stalled for the whole merge.
// A merge with both lists empty stays idle and emits nothing.
// Reset (rst_n, synchronous, active low) clears counts, drop flag, sequencer and out_valid;
//   list memories are not cleared and need no clearing pass.
module two_way_sorted_merge #(
  parameter int DEPTH     = tsm_pkg::DEPTH_DEF,
  parameter int DATA_BITS = tsm_pkg::DATA_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [tsm_pkg::OPCODE_BITS-1:0]        in_opcode,
  input  logic signed [tsm_pkg::VALUE_BITS-1:0]  in_value,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tsm_pkg::VALUE_BITS-1:0]  out_merged_value,
  output logic                                   out_from_b,
  output logic                                   out_last,
  output logic                                   out_dropped
);

  // count width holds DEPTH itself; address width indexes DEPTH entries
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  tsm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic          ovf_r, ovf_nxt;
  // merge read pointers; each memory is always reading at the next pointer
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;

  logic          wr_a, wr_b;
  logic signed [DATA_BITS-1:0] wdata;
  logic signed [DATA_BITS-1:0] rd_a, rd_b, head;

  logic          a_left, b_left, take_b, load, last_item;

  logic                                  out_valid_r, out_valid_nxt;
  logic signed [tsm_pkg::VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                                  out_from_b_r, out_from_b_nxt;
  logic                                  out_last_r, out_last_nxt;
  logic                                  out_dropped_r, out_dropped_nxt;

  // the signed cast extends or truncates the 32-bit request value to the stored width
  assign wdata = DATA_BITS'(in_value);

  tsm_list_mem #(.DEPTH(DEPTH), .DATA_BITS(DATA_BITS), .AW(AW)) u_mem_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[AW-1:0]),
    .wr_data (wdata),
    .rd_addr (ia_nxt[AW-1:0]),
    .rd_data (rd_a)
  );

  tsm_list_mem #(.DEPTH(DEPTH), .DATA_BITS(DATA_BITS), .AW(AW)) u_mem_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[AW-1:0]),
    .wr_data (wdata),
    .rd_addr (ib_nxt[AW-1:0]),
    .rd_data (rd_b)
  );

  // Heads are valid in ST_MERGE: the pointers were presented as read
  // addresses at the previous edge, and no write happens during a merge.
  // A merge request itself writes nothing, so the first read never races an append.
  assign a_left = (ia_r != cnt_a_r);
  assign b_left = (ib_r != cnt_b_r);
  // stable: B goes first only when strictly smaller
  assign take_b = !a_left || (b_left && (rd_b < rd_a));
  assign head   = take_b ? rd_b : rd_a;

  always_comb begin
    state_nxt       = state_r;
    cnt_a_nxt       = cnt_a_r;
    cnt_b_nxt       = cnt_b_r;
    ovf_nxt         = ovf_r;
    ia_nxt          = ia_r;
    ib_nxt          = ib_r;
    wr_a            = 1'b0;
    wr_b            = 1'b0;
    in_stall        = 1'b0;
    load            = 1'b0;
    last_item       = 1'b0;
    // output register drains when taken, holds while stalled
    out_valid_nxt   = out_valid_r && out_stall;
    out_value_nxt   = out_value_r;
    out_from_b_nxt  = out_from_b_r;
    out_last_nxt    = out_last_r;
    out_dropped_nxt = out_dropped_r;

    unique case (state_r)
      tsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            tsm_pkg::OP_APPEND_A: begin
              if (cnt_a_r == FULL) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end
            end
            tsm_pkg::OP_APPEND_B: begin
              if (cnt_b_r == FULL) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end
            tsm_pkg::OP_MERGE: begin
              // empty merge still clears the drop report
              if (cnt_a_r == '0 && cnt_b_r == '0) begin
                ovf_nxt = 1'b0;
              end else begin
                state_nxt = tsm_pkg::ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      tsm_pkg::ST_MERGE: begin
        in_stall = 1'b1;
        if (!out_valid_r || !out_stall) begin
          load = 1'b1;
          if (take_b) begin
            ib_nxt = ib_r + 1'b1;
          end else begin
            ia_nxt = ia_r + 1'b1;
          end
          last_item       = (ia_nxt == cnt_a_r) && (ib_nxt == cnt_b_r);
          out_valid_nxt   = 1'b1;
          out_value_nxt   = tsm_pkg::VALUE_BITS'(head);
          out_from_b_nxt  = take_b;
          out_last_nxt    = last_item;
          out_dropped_nxt = ovf_r;
          if (last_item) begin
            state_nxt = tsm_pkg::ST_IDLE;
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ovf_nxt   = 1'b0;
            ia_nxt    = '0;
            ib_nxt    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsm_pkg::ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_value_r   <= out_value_nxt;
    out_from_b_r  <= out_from_b_nxt;
    out_last_r    <= out_last_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_from_b       = out_from_b_r;
  assign out_last         = out_last_r;
  assign out_dropped      = out_dropped_r;

  // counts never pass the list depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= FULL) && (cnt_b_r <= FULL))
    else $error("list count beyond depth");

  // a popped head always comes from a list that still has entries
  a_pop_legal: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (take_b ? b_left : a_left))
    else $error("merge popped an exhausted list");

  // the final item ends the merge with both lists and the drop flag cleared
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_item) |=> (state_r == tsm_pkg::ST_IDLE && cnt_a_r == '0
                             && cnt_b_r == '0 && !ovf_r && out_valid_r && out_last_r))
    else $error("merge did not close cleanly");

  // pointers rest at zero between merges
  a_idle_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsm_pkg::ST_IDLE) |-> (ia_r == '0 && ib_r == '0))
    else $error("read pointers not at zero while idle");

endmodule
